>>> rtl/pidrg_pkg.sv
`timescale 1ns / 1ps
package pidrg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int GAIN_W   = 16;

    localparam int ERR_W    = SAMPLE_W + 1;   // setpoint - measurement
    localparam int DIFF_W   = SAMPLE_W + 2;   // error - previous error
    localparam int ACCX_W   = ACC_W + 1;      // integrator sum before saturation
    localparam int MAG_W    = (ACC_W > DIFF_W) ? ACC_W : DIFF_W;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int SUM_W    = PROD_W + 3;     // three signed terms added
    localparam int CFG_W    = (SAMPLE_W > GAIN_W) ? SAMPLE_W : GAIN_W;

    // serial unit: one multiplier bit, then one quotient bit, per cycle
    localparam int TERM_STEPS = GAIN_W + PROD_W;
    localparam int STEP_W     = $clog2(TERM_STEPS);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_LOWER = 3'd0,
        CFG_OUT_UPPER = 3'd1,
        CFG_KP_NUM    = 3'd2,
        CFG_KP_DEN    = 3'd3,
        CFG_KI_NUM    = 3'd4,
        CFG_KI_DEN    = 3'd5,
        CFG_KD_NUM    = 3'd6,
        CFG_KD_DEN    = 3'd7
    } cfg_idx_t;

endpackage

>>> rtl/pidrg_term.sv
`timescale 1ns / 1ps
// Bit-serial |operand| * num / den: shift-add multiply, then restoring divide
// in the same shift register.
module pidrg_term import pidrg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  mag,
    input  logic [GAIN_W-1:0] num,
    input  logic [GAIN_W-1:0] den,
    output logic              done,
    output logic [PROD_W-1:0] quo
);

    logic              run_reg,  run_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic [PROD_W-1:0] acc_reg,  acc_next;
    logic [GAIN_W-1:0] rem_reg,  rem_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [GAIN_W-1:0] den_reg;

    logic              mul_phase;
    logic              last_step;
    logic [MAG_W:0]    part_sum;
    logic [GAIN_W:0]   trial;
    logic              fits;

    assign mul_phase = cnt_reg < STEP_W'(GAIN_W);
    assign last_step = cnt_reg == STEP_W'(TERM_STEPS - 1);
    assign done      = run_reg && last_step;
    assign quo       = acc_reg;

    always_comb begin
        part_sum = {1'b0, acc_reg[PROD_W-1:GAIN_W]}
                 + (acc_reg[0] ? {1'b0, mag_reg} : '0);
        trial    = {rem_reg, acc_reg[PROD_W-1]};
        fits     = trial >= {1'b0, den_reg};
        run_next = run_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = '0;
            acc_next = {{MAG_W{1'b0}}, num};
            rem_next = '0;
        end else if (run_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (last_step) begin
                run_next = 1'b0;
            end
            if (mul_phase) begin
                acc_next = {part_sum, acc_reg[GAIN_W-1:1]};
            end else begin
                acc_next = {acc_reg[PROD_W-2:0], fits};
                rem_next = fits ? GAIN_W'(trial - {1'b0, den_reg}) : trial[GAIN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (start) begin
            mag_reg <= mag;
            den_reg <= (den == '0) ? GAIN_W'(1) : den;   // zero acts as one
        end
    end

endmodule

>>> rtl/pid_rational_gain_antiwindup.sv
`timescale 1ns / 1ps
// PID regulator with rational gains and conditional-integration anti-windup.
// An update item (s_tuser = 0) passes ST_PREP, forming the error, integrator
// candidate and error difference, ST_LOAD, loading the term units, ST_RUN, the
// three bit-serial term units side by side (16 multiplier bits then 48
// quotient bits, one per cycle), and ST_SIGN, ST_TOTAL and ST_FINISH to sign,
// add and clamp. A reset item (s_tuser = 1) skips to ST_FINISH. The result is
// held in an output register, so the next item is taken while the previous
// result still waits on m_tready. Configuration is written through cfg_wen /
// cfg_index / cfg_wdata while idle, a user rule, not enforced by the block. A
// zero denominator behaves as one; the integrator saturates at 32 bits.
module pid_rational_gain_antiwindup import pidrg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,    // [15:0] measured, [31:16] target
    input  logic                 s_tuser,    // [0] req_type: 0 update, 1 reset
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata     // [15:0] drive, [16] saturated,
                                             // [17] integrating, rest zero
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PREP   = 7'b0000010,
        ST_LOAD   = 7'b0000100,
        ST_RUN    = 7'b0001000,
        ST_SIGN   = 7'b0010000,
        ST_TOTAL  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [SAMPLE_W-1:0] out_lower_reg, out_upper_reg;
    logic [GAIN_W-1:0] kp_num_reg, kp_den_reg, ki_num_reg, ki_den_reg;
    logic [GAIN_W-1:0] kd_num_reg, kd_den_reg;

    // regulator state
    logic signed [SAMPLE_W-1:0] setpoint_reg;
    logic signed [ACC_W-1:0]    error_sum_reg;
    logic signed [ERR_W-1:0]    last_error_reg;
    logic signed [SAMPLE_W-1:0] held_drive_reg;

    // item being worked on
    logic                       req_reg;
    logic signed [SAMPLE_W-1:0] meas_reg, target_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ACC_W-1:0]    cand_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [SUM_W-1:0]    tp_reg, ti_reg, td_reg, total_reg;

    // output register
    logic                       m_tvalid_reg;
    logic [23:0]                m_tdata_reg;

    logic                       in_take, out_free;
    logic signed [ERR_W-1:0]    err_calc, new_last_error;
    logic signed [ACCX_W-1:0]   cand_wide;
    logic signed [ACC_W-1:0]    cand_calc;
    logic signed [DIFF_W-1:0]   diff_calc;
    logic [ERR_W-1:0]           err_mag;
    logic [ACC_W-1:0]           cand_mag;
    logic [DIFF_W-1:0]          diff_mag;
    logic                       term_start;
    logic                       p_done, i_done, d_done;
    logic [PROD_W-1:0]          p_quo, i_quo, d_quo;
    logic signed [SUM_W-1:0]    p_ext, i_ext, d_ext;
    logic signed [SUM_W-1:0]    lo_ext, hi_ext;
    logic                       above, below, sat, commit, err_pos, err_neg;
    logic signed [SAMPLE_W-1:0] drive_calc;

    assign s_tready = state_reg == ST_IDLE;
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // error, integrator candidate (saturating), error difference
    always_comb begin
        err_calc  = ERR_W'(setpoint_reg) - ERR_W'(meas_reg);
        cand_wide = ACCX_W'(error_sum_reg) + ACCX_W'(err_calc);
        if (cand_wide[ACCX_W-1] != cand_wide[ACCX_W-2]) begin
            cand_calc = cand_wide[ACCX_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            cand_calc = cand_wide[ACC_W-1:0];
        end
        diff_calc = DIFF_W'(err_calc) - DIFF_W'(last_error_reg);
    end

    // magnitudes into the serial units
    assign err_mag  = err_reg[ERR_W-1]   ? ERR_W'(-err_reg)   : ERR_W'(err_reg);
    assign cand_mag = cand_reg[ACC_W-1]  ? ACC_W'(-cand_reg)  : ACC_W'(cand_reg);
    assign diff_mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign term_start = state_reg == ST_LOAD;

    pidrg_term u_term_p (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (term_start),
        .mag     (MAG_W'(err_mag)),
        .num     (kp_num_reg),
        .den     (kp_den_reg),
        .done    (p_done),
        .quo     (p_quo)
    );

    pidrg_term u_term_i (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (term_start),
        .mag     (MAG_W'(cand_mag)),
        .num     (ki_num_reg),
        .den     (ki_den_reg),
        .done    (i_done),
        .quo     (i_quo)
    );

    pidrg_term u_term_d (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (term_start),
        .mag     (MAG_W'(diff_mag)),
        .num     (kd_num_reg),
        .den     (kd_den_reg),
        .done    (d_done),
        .quo     (d_quo)
    );

    assign p_ext = SUM_W'(p_quo);
    assign i_ext = SUM_W'(i_quo);
    assign d_ext = SUM_W'(d_quo);

    // clamp and anti-windup decision
    always_comb begin
        lo_ext  = SUM_W'(out_lower_reg);
        hi_ext  = SUM_W'(out_upper_reg);
        above   = total_reg > hi_ext;
        below   = total_reg < lo_ext;
        sat     = above || below;
        err_neg = err_reg[ERR_W-1];
        err_pos = !err_reg[ERR_W-1] && (err_reg != '0);
        if (above) begin
            drive_calc = out_upper_reg;
        end else if (below) begin
            drive_calc = out_lower_reg;
        end else begin
            drive_calc = total_reg[SAMPLE_W-1:0];
        end
        // integrate when free, or when the error drives back off the limit
        commit = !sat || ((total_reg >= hi_ext) && err_neg)
                      || ((total_reg <= lo_ext) && err_pos);
        new_last_error = ERR_W'(target_reg) - ERR_W'(meas_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    state_next = s_tuser ? ST_FINISH : ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_RUN;
            ST_RUN: begin
                if (p_done) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:  state_next = ST_TOTAL;
            ST_TOTAL: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control, configuration and regulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            out_lower_reg  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            out_upper_reg  <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            kp_num_reg     <= GAIN_W'(1);
            kp_den_reg     <= GAIN_W'(1);
            ki_num_reg     <= '0;
            ki_den_reg     <= GAIN_W'(1);
            kd_num_reg     <= '0;
            kd_den_reg     <= GAIN_W'(1);
            setpoint_reg   <= '0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            held_drive_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_OUT_LOWER: out_lower_reg <= cfg_wdata[SAMPLE_W-1:0];
                    CFG_OUT_UPPER: out_upper_reg <= cfg_wdata[SAMPLE_W-1:0];
                    CFG_KP_NUM:    kp_num_reg    <= cfg_wdata[GAIN_W-1:0];
                    CFG_KP_DEN:    kp_den_reg    <= cfg_wdata[GAIN_W-1:0];
                    CFG_KI_NUM:    ki_num_reg    <= cfg_wdata[GAIN_W-1:0];
                    CFG_KI_DEN:    ki_den_reg    <= cfg_wdata[GAIN_W-1:0];
                    CFG_KD_NUM:    kd_num_reg    <= cfg_wdata[GAIN_W-1:0];
                    CFG_KD_DEN:    kd_den_reg    <= cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
                if (req_reg) begin
                    setpoint_reg   <= target_reg;
                    error_sum_reg  <= '0;
                    last_error_reg <= new_last_error;
                end else begin
                    if (commit) begin
                        error_sum_reg <= cand_reg;
                    end
                    last_error_reg <= err_reg;
                    held_drive_reg <= drive_calc;
                end
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (in_take) begin
            req_reg    <= s_tuser;
            meas_reg   <= s_tdata[SAMPLE_W-1:0];
            target_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (state_reg == ST_PREP) begin
            err_reg  <= err_calc;
            cand_reg <= cand_calc;
            diff_reg <= diff_calc;
        end
        if (state_reg == ST_SIGN) begin
            tp_reg <= err_reg[ERR_W-1]   ? -p_ext : p_ext;
            ti_reg <= cand_reg[ACC_W-1]  ? -i_ext : i_ext;
            td_reg <= diff_reg[DIFF_W-1] ? -d_ext : d_ext;
        end
        if (state_reg == ST_TOTAL) begin
            total_reg <= tp_reg + ti_reg + td_reg;
        end
        if (state_reg == ST_FINISH && out_free) begin
            if (req_reg) begin
                m_tdata_reg <= {6'd0, 1'b0, 1'b0, held_drive_reg};
            end else begin
                m_tdata_reg <= {6'd0, commit, sat, drive_calc};
            end
        end
    end

`ifndef SYNTHESIS
    a_terms_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_done == i_done) && (i_done == d_done))
        else $error("term units out of step");

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        p_done |-> state_reg == ST_RUN)
        else $error("term unit finished outside run state");

    a_clamp_or_integrate: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free && !req_reg)
            |=> m_tvalid_reg && (m_tdata_reg[16] || m_tdata_reg[17]))
        else $error("unsaturated update item did not integrate");
`endif

endmodule

>>> verif/pid_rational_gain_antiwindup_tb.sv
`timescale 1ns / 1ps
module pid_rational_gain_antiwindup_tb;
    import pidrg_pkg::*;

    // item kinds carried on s_tuser
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_RESET  = 1'b1;

    localparam int MAX_IDLE     = 17;     // longest per-item gap on either side
    localparam int QUIET_LIMIT  = 4000;   // cycles with no handshake or register write
    localparam int DRAIN_CYCLES = 80;     // one update item plus slack
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 120;

    // magnitude ceiling of one scaled term
    localparam longint unsigned TERM_CAP = 64'd1 << 61;

    typedef struct packed {
        logic        hold_first;   // sender waits for all results before this item
        logic        kind;
        logic [15:0] target;
        logic [15:0] meas;
    } pid_item_t;

    // laid out as on m_tdata: drive lowest, then saturated, then integrating
    typedef struct packed {
        logic        integ;
        logic        sat;
        logic [15:0] drive;
    } pid_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wen   = 1'b0;
    cfg_idx_t          cfg_index = CFG_OUT_LOWER;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;   // [15:0] measured, [31:16] target
    logic              s_tuser   = 1'b0; // [0] req_type
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;          // [15:0] drive, [16] saturated, [17] integrating

    pid_rational_gain_antiwindup u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Regulator model: own copy of registers and loop state
    // ------------------------------------------------------------------
    logic [15:0] lim_lo = 16'h8000;
    logic [15:0] lim_hi = 16'h7FFF;
    logic [15:0] kp_n = 16'd1, kp_d = 16'd1;
    logic [15:0] ki_n = 16'd0, ki_d = 16'd1;
    logic [15:0] kd_n = 16'd0, kd_d = 16'd1;

    longint setpoint_q = 0;
    longint integ_sum  = 0;
    longint prev_err   = 0;
    longint last_drive = 0;

    pid_item_t   stim_q[$];            // items waiting for the driver
    pid_result_t expected_drive_q[$];  // predicted results, oldest first

    int errors      = 0;
    int n_updates   = 0;
    int n_resets    = 0;
    int n_sat       = 0;
    int n_integ     = 0;
    int n_settings  = 0;
    int quiet       = 0;

    // operand * num / den, truncated toward zero, magnitude capped
    function automatic longint gain_term(longint operand, logic [15:0] num,
                                         logic [15:0] den);
        longint unsigned mag, n, d, prod, q;
        n   = num;
        d   = (den == 16'd0) ? 64'd1 : den;   // zero denominator acts as one
        mag = (operand < 0) ? -operand : operand;
        if (n != 0 && mag > TERM_CAP / n)
            prod = TERM_CAP;
        else
            prod = mag * n;
        q = prod / d;
        if (q > TERM_CAP)
            q = TERM_CAP;
        return (operand < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic pid_result_t compute_drive(pid_item_t it);
        pid_result_t        res;
        logic signed [15:0] meas_s, tgt_s, lo_s, hi_s;
        longint             err, cand, total, lo, hi, drv;
        logic               sat, commit;
        meas_s = it.meas;
        tgt_s  = it.target;
        lo_s   = lim_lo;
        hi_s   = lim_hi;
        lo     = lo_s;
        hi     = hi_s;
        if (it.kind == REQ_RESET) begin
            // new setpoint, integrator cleared, output held
            setpoint_q = tgt_s;
            integ_sum  = 0;
            prev_err   = setpoint_q - meas_s;
            res.drive  = last_drive[15:0];
            res.sat    = 1'b0;
            res.integ  = 1'b0;
        end else begin
            err  = setpoint_q - meas_s;
            cand = integ_sum + err;
            if (cand > ACC_MAX) cand = ACC_MAX;
            if (cand < ACC_MIN) cand = ACC_MIN;
            total = gain_term(err, kp_n, kp_d) + gain_term(cand, ki_n, ki_d)
                  + gain_term(err - prev_err, kd_n, kd_d);
            // upper limit wins when the limits are inverted
            if (total > hi) begin
                drv = hi;
                sat = 1'b1;
            end else if (total < lo) begin
                drv = lo;
                sat = 1'b1;
            end else begin
                drv = total;
                sat = 1'b0;
            end
            commit = !sat || (total >= hi && err < 0) || (total <= lo && err > 0);
            if (commit)
                integ_sum = cand;
            prev_err   = err;
            last_drive = drv;
            res.drive  = drv[15:0];
            res.sat    = sat;
            res.integ  = commit;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 12));
        endcase
    endfunction

    task automatic push_item(logic kind, logic [15:0] meas, logic [15:0] tgt,
                             logic hold_first);
        pid_item_t it;
        it.hold_first = hold_first;
        it.kind       = kind;
        it.target     = tgt;
        it.meas       = meas;
        stim_q.push_back(it);
    endtask

    // one register write per clock; model copy follows at once, since
    // nothing is in flight while registers change
    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_OUT_LOWER: lim_lo = val;
            CFG_OUT_UPPER: lim_hi = val;
            CFG_KP_NUM:    kp_n   = val;
            CFG_KP_DEN:    kp_d   = val;
            CFG_KI_NUM:    ki_n   = val;
            CFG_KI_DEN:    ki_d   = val;
            CFG_KD_NUM:    kd_n   = val;
            CFG_KD_DEN:    kd_d   = val;
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [15:0] lo, logic [15:0] hi,
                             logic [15:0] pn, logic [15:0] pd,
                             logic [15:0] in, logic [15:0] id,
                             logic [15:0] dn, logic [15:0] dd);
        write_reg(CFG_OUT_LOWER, lo);
        write_reg(CFG_OUT_UPPER, hi);
        write_reg(CFG_KP_NUM, pn);
        write_reg(CFG_KP_DEN, pd);
        write_reg(CFG_KI_NUM, in);
        write_reg(CFG_KI_DEN, id);
        write_reg(CFG_KD_NUM, dn);
        write_reg(CFG_KD_DEN, dd);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        n_settings++;
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding;
    // sampled on the falling edge so the rising-edge updates have settled
    task automatic wait_idle();
        while (stim_q.size() != 0 || s_tvalid || expected_drive_q.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items, random gap before each one
    // ------------------------------------------------------------------
    pid_item_t live_item;
    int        tx_gap   = 0;
    logic      tx_lazy  = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_drive_q.push_back(compute_drive(live_item));
                if (live_item.kind == REQ_RESET)
                    n_resets++;
                else
                    n_updates++;
                if ($urandom_range(0, 49) == 0)
                    tx_lazy = !tx_lazy;
                tx_gap = tx_lazy ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (s_tvalid && !s_tready) begin
                // item still on offer, keep it stable
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (stim_q.size() != 0 &&
                         !(stim_q[0].hold_first && expected_drive_q.size() != 0)) begin
                live_item = stim_q.pop_front();
                s_tdata   <= {live_item.target, live_item.meas};
                s_tuser   <= live_item.kind;
                s_tvalid  <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compares against oldest prediction
    // ------------------------------------------------------------------
    int   rx_stall = 0;
    logic rx_lazy  = 1'b0;

    always @(posedge aclk) begin
        pid_result_t want, got;
        int          hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            hold = rx_stall;
            if (m_tvalid && m_tready) begin
                got = m_tdata[17:0];
                if (expected_drive_q.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, actual drive %0d",
                             $time, $signed(got.drive));
                    errors++;
                end else begin
                    want = expected_drive_q.pop_front();
                    if (got.drive !== want.drive) begin
                        $display("%0t: drive: expected %0d, actual %0d",
                                 $time, $signed(want.drive), $signed(got.drive));
                        errors++;
                    end
                    if (got.sat !== want.sat) begin
                        $display("%0t: saturated: expected %0b, actual %0b",
                                 $time, want.sat, got.sat);
                        errors++;
                    end
                    if (got.integ !== want.integ) begin
                        $display("%0t: integrating: expected %0b, actual %0b",
                                 $time, want.integ, got.integ);
                        errors++;
                    end
                    if (m_tdata[23:18] !== 6'd0) begin
                        $display("%0t: pad bits: expected 0, actual %0h",
                                 $time, m_tdata[23:18]);
                        errors++;
                    end
                    n_sat   += want.sat;
                    n_integ += want.integ;
                end
                if ($urandom_range(0, 49) == 0)
                    rx_lazy = !rx_lazy;
                hold = rx_lazy ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                rx_stall = hold - 1;
            end else begin
                m_tready <= 1'b1;
                rx_stall = 0;
            end
        end
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet);
                $display("pid_rational_gain_antiwindup_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed phases, then random phases with random settings
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] sp_guess, meas, lo, hi;
        int          p, i, r;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: unit P gain, full limits, input extremes
        push_item(REQ_UPDATE, 16'h0000, 16'hFFFF, 1'b0);
        push_item(REQ_UPDATE, 16'h7FFF, 16'h0000, 1'b0);
        push_item(REQ_UPDATE, 16'h8000, 16'h0000, 1'b0);
        push_item(REQ_RESET,  16'h8000, 16'h7FFF, 1'b0);
        push_item(REQ_UPDATE, 16'h8000, 16'h5555, 1'b0);   // error beyond upper limit
        push_item(REQ_RESET,  16'h7FFF, 16'h8000, 1'b0);
        push_item(REQ_UPDATE, 16'h7FFF, 16'hAAAA, 1'b0);   // error beyond lower limit
        push_item(REQ_UPDATE, 16'd12345, 16'h0000, 1'b0);
        wait_idle();

        // zero denominators; wind the integrator up to +2000
        set_gains(16'h8000, 16'h7FFF, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
        push_item(REQ_RESET,  16'hFC18, 16'h0000, 1'b0);   // meas -1000
        push_item(REQ_UPDATE, 16'hFC18, 16'h0000, 1'b0);
        push_item(REQ_UPDATE, 16'hFC18, 16'h0000, 1'b0);
        wait_idle();

        // narrow limits: saturated high but error unwinds, then plain saturation
        set_gains(16'hFE0C, 16'd500, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
        push_item(REQ_UPDATE, 16'd100, 16'h0000, 1'b0);
        push_item(REQ_UPDATE, 16'hFF9C, 16'h0000, 1'b0);
        push_item(REQ_RESET,  16'd1000, 16'h0000, 1'b0);
        wait_idle();

        // wind down to -2000 with full limits
        set_gains(16'h8000, 16'h7FFF, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
        push_item(REQ_UPDATE, 16'd1000, 16'h0000, 1'b0);
        push_item(REQ_UPDATE, 16'd1000, 16'h0000, 1'b0);
        wait_idle();

        // saturated low while error unwinds
        set_gains(16'hFE0C, 16'd500, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
        push_item(REQ_UPDATE, 16'hFF9C, 16'h0000, 1'b0);
        wait_idle();

        // inverted limits, derivative at unit gain
        set_gains(16'd100, 16'hFF9C, 16'd1, 16'd1, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF);
        push_item(REQ_RESET,  16'h0000, 16'h0000, 1'b0);
        push_item(REQ_UPDATE, 16'hFE0C, 16'h0000, 1'b0);
        push_item(REQ_UPDATE, 16'd500, 16'h0000, 1'b0);
        push_item(REQ_UPDATE, 16'h0000, 16'h0000, 1'b0);
        wait_idle();

        // largest gains; one item held back until the pipe drains
        set_gains(16'h8000, 16'h7FFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0);
        push_item(REQ_UPDATE, 16'h7FFF, 16'h0000, 1'b0);
        push_item(REQ_UPDATE, 16'h8000, 16'h0000, 1'b0);
        push_item(REQ_RESET,  16'h8000, 16'h7FFF, 1'b1);
        push_item(REQ_UPDATE, 16'h8000, 16'h0000, 1'b0);
        wait_idle();

        // random phases: new settings each, mostly updates around setpoint
        for (p = 0; p < RAND_PHASES; p++) begin
            r = $urandom_range(0, 4);
            case (r)
                0: begin
                    lo = 16'h8000;
                    hi = 16'h7FFF;
                end
                1: begin
                    lo = -16'($urandom_range(0, 3000));
                    hi = 16'($urandom_range(0, 3000));
                end
                2: begin
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                end
                3: begin
                    lo = 16'($urandom_range(0, 200)) - 16'd100;
                    hi = lo;
                end
                default: begin
                    lo = 16'h7FFF;
                    hi = 16'h8000;
                end
            endcase
            set_gains(lo, hi, rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                      rand_gain(), rand_gain());
            sp_guess = rand_sample();
            push_item(REQ_RESET, rand_sample(), sp_guess, 1'b0);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    sp_guess = rand_sample();
                    push_item(REQ_RESET, rand_sample(), sp_guess,
                              $urandom_range(0, 99) == 0);
                end else begin
                    if ($urandom_range(0, 99) < 60)
                        meas = sp_guess + 16'($urandom_range(0, 400)) - 16'd200;
                    else
                        meas = rand_sample();
                    push_item(REQ_UPDATE, meas, 16'($urandom),
                              $urandom_range(0, 99) == 0);
                end
            end
            wait_idle();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d update and %0d reset items over %0d register settings",
                 n_updates, n_resets, n_settings);
        $display("results: %0d saturated, %0d with integrator commit", n_sat, n_integ);
        if (errors == 0)
            $display("pid_rational_gain_antiwindup_tb OK");
        else
            $display("pid_rational_gain_antiwindup_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pidrg_pkg.sv
rtl/pidrg_term.sv
rtl/pid_rational_gain_antiwindup.sv
verif/pid_rational_gain_antiwindup_tb.sv
